>>> rtl/ego_pkg.sv
package ego_pkg;

	// Longest zero prefix accepted before a code is flagged as an error
	localparam int unsigned MAX_PREFIX = 31;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 3;
	localparam int unsigned ZC_W   = 6;
	localparam int unsigned VAL_W  = 32;

	localparam logic [POS_W-1:0] TOP_BIT = POS_W'(BYTE_W - 1);

	// Two-entry queues on both sides of the decoder
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = 1;
	localparam int unsigned Q_CNT_W = 2;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              start_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] code_num;
		logic             prefix_error;
		logic             last_of_byte;
	} out_item_t;

	// Occupancy of a queue as seen by its neighbor
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/exp_golomb_ue_decoder_core.sv
// Unsigned Exp-Golomb decoder. Bytes are pushed in and read most significant bit
// first; each finished code comes out as one transaction on the result side, in
// stream order, with last_of_byte set on the final code finished by a byte and
// prefix_error set (code_num zero) when a zero prefix runs past 31 bits. Setting
// start_of_stream drops any partial code before that byte. The decoder handles
// one bit per cycle while it is not stalled; that bit-serial step sets the
// sustained rate. Two-entry queues sit in front of and behind the decoder, so
// bytes are taken while results wait, and the decoder stalls only while a
// finished code cannot be written to a full result queue.
module exp_golomb_ue_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ego_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output ego_pkg::out_item_t result
);
	import ego_pkg::*;

	in_item_t  head;
	q_status_t fetch_status;
	logic      fetch_take;
	logic      res_wr;
	out_item_t res_item;
	q_status_t res_status;

	ego_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.take   (fetch_take),
		.head   (head),
		.status (fetch_status)
	);

	ego_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fetch        (head),
		.fetch_status (fetch_status),
		.fetch_take   (fetch_take),
		.res_wr       (res_wr),
		.res_item     (res_item),
		.res_status   (res_status)
	);

	ego_res_queue u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.wr_item (res_item),
		.status  (res_status),
		.pop     (pop),
		.result  (result)
	);

	assign empty = res_status.empty;

endmodule

>>> rtl/ego_front.sv
module ego_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ego_pkg::in_item_t item,
	output logic             full,
	input  logic             take,
	output ego_pkg::in_item_t head,
	output ego_pkg::q_status_t status
);
	import ego_pkg::*;

	in_item_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign status.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign full         = status.full;
	assign head         = mem_q[rd_ptr_q];

	assign do_wr = push && !status.full;
	assign do_rd = take && !status.empty;

	// Store accepted bytes
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ego_res_queue.sv
module ego_res_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  ego_pkg::out_item_t wr_item,
	output ego_pkg::q_status_t status,
	input  logic              pop,
	output ego_pkg::out_item_t result
);
	import ego_pkg::*;

	out_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign status.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign result       = mem_q[rd_ptr_q];

	assign do_wr = wr && !status.full;
	assign do_rd = pop && !status.empty;

	// Store finished codes
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ego_back.sv
module ego_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ego_pkg::in_item_t  fetch,
	input  ego_pkg::q_status_t fetch_status,
	output logic               fetch_take,
	output logic               res_wr,
	output ego_pkg::out_item_t res_item,
	input  ego_pkg::q_status_t res_status
);
	import ego_pkg::*;

	// Current byte and bit position
	logic              busy_q;
	logic [BYTE_W-1:0] byte_q;
	logic [POS_W-1:0]  pos_q;

	// Code state
	logic              in_suffix_q;
	logic [ZC_W-1:0]   zero_count_q;
	logic [VAL_W-1:0]  suffix_value_q;
	logic [ZC_W-1:0]   suffix_left_q;

	// Result held until it is known whether it closes its byte
	logic              pend_valid_q;
	logic              pend_done_q;
	logic [VAL_W-1:0]  pend_val_q;
	logic              pend_err_q;

	logic              cur_bit;
	logic              produces;
	logic [VAL_W-1:0]  new_val;
	logic              new_err;
	logic              step_go;
	logic              load;
	logic              last_bit;
	logic              in_suffix_n;
	logic [ZC_W-1:0]   zero_count_n;
	logic [VAL_W-1:0]  suffix_value_n;
	logic [ZC_W-1:0]   suffix_left_n;
	logic [ZC_W-1:0]   zc_inc;
	logic [VAL_W-1:0]  sv_shift;
	logic [ZC_W-1:0]   sl_dec;
	logic [VAL_W-1:0]  base;

	assign cur_bit  = byte_q[pos_q];
	assign last_bit = (pos_q == '0);
	assign zc_inc   = zero_count_q + 1'b1;
	assign sv_shift = {suffix_value_q[VAL_W-2:0], cur_bit};
	assign sl_dec   = (suffix_left_q != '0) ? suffix_left_q - 1'b1 : suffix_left_q;
	assign base     = (VAL_W'(1) << zero_count_q[4:0]) - VAL_W'(1);

	// Decode one bit of the current byte
	always_comb begin
		produces       = 1'b0;
		new_val        = '0;
		new_err        = 1'b0;
		in_suffix_n    = in_suffix_q;
		zero_count_n   = zero_count_q;
		suffix_value_n = suffix_value_q;
		suffix_left_n  = suffix_left_q;
		if (!in_suffix_q) begin
			if (!cur_bit) begin
				if (zc_inc > ZC_W'(MAX_PREFIX)) begin
					produces       = 1'b1;
					new_err        = 1'b1;
					zero_count_n   = '0;
					suffix_value_n = '0;
					suffix_left_n  = '0;
				end else begin
					zero_count_n = zc_inc;
				end
			end else if (zero_count_q == '0) begin
				produces       = 1'b1;
				suffix_value_n = '0;
				suffix_left_n  = '0;
			end else begin
				in_suffix_n    = 1'b1;
				suffix_left_n  = zero_count_q;
				suffix_value_n = '0;
			end
		end else begin
			suffix_value_n = sv_shift;
			suffix_left_n  = sl_dec;
			if (sl_dec == '0) begin
				produces       = 1'b1;
				new_val        = base + sv_shift;
				in_suffix_n    = 1'b0;
				zero_count_n   = '0;
				suffix_value_n = '0;
				suffix_left_n  = '0;
			end
		end
	end

	// Stall the bit step only when a held result must leave and the queue is full
	assign step_go = busy_q &&
		(!pend_valid_q || !res_status.full || (!pend_done_q && !produces));
	assign res_wr  = pend_valid_q && !res_status.full &&
		(pend_done_q || (step_go && produces));
	assign res_item.code_num     = pend_val_q;
	assign res_item.prefix_error = pend_err_q;
	assign res_item.last_of_byte = pend_done_q;

	assign load       = !fetch_status.empty && (!busy_q || (step_go && last_bit));
	assign fetch_take = load;

	// Capture the next byte
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= fetch.data_byte;
		end
	end

	// Hold the pending result payload
	always_ff @(posedge clk) begin
		if (step_go && produces) begin
			pend_val_q <= new_val;
			pend_err_q <= new_err;
		end
	end

	// Advance bit position, code state and pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pos_q          <= '0;
			in_suffix_q    <= 1'b0;
			zero_count_q   <= '0;
			suffix_value_q <= '0;
			suffix_left_q  <= '0;
			pend_valid_q   <= 1'b0;
			pend_done_q    <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				pos_q  <= TOP_BIT;
			end else if (step_go) begin
				busy_q <= !last_bit;
				pos_q  <= pos_q - 1'b1;
			end

			if (load && fetch.start_of_stream) begin
				in_suffix_q    <= 1'b0;
				zero_count_q   <= '0;
				suffix_value_q <= '0;
				suffix_left_q  <= '0;
			end else if (step_go) begin
				in_suffix_q    <= in_suffix_n;
				zero_count_q   <= zero_count_n;
				suffix_value_q <= suffix_value_n;
				suffix_left_q  <= suffix_left_n;
			end

			if (step_go && produces) begin
				pend_valid_q <= 1'b1;
				pend_done_q  <= last_bit;
			end else begin
				if (res_wr) begin
					pend_valid_q <= 1'b0;
				end
				if (step_go && last_bit && pend_valid_q && !res_wr) begin
					pend_done_q <= 1'b1;
				end
			end
		end
	end

	a_wr_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> pend_valid_q)
		else $error("result written with nothing pending");

	a_last_marks_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && produces && last_bit) |=> (pend_valid_q && pend_done_q))
		else $error("result from last bit not marked last of byte");

	a_suffix_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_suffix_q |-> (zero_count_q != '0 && zero_count_q <= ZC_W'(MAX_PREFIX)))
		else $error("suffix read with bad prefix length");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && !last_bit) |=> (busy_q && pos_q == $past(pos_q) - 1'b1))
		else $error("bit position did not advance");

endmodule
